@@ src/e2c_pkg.sv @@
// shared types and widths for the epoch-to-calendar-date converter
// no dependencies; imported by the front, back and top level modules
package e2c_pkg;

  localparam int unsigned EpochW  = 32;
  localparam int unsigned OffsetW = 17;

  // time-zone offset after reset, in seconds
  localparam logic signed [OffsetW-1:0] OffsetReset = 17'sd28800;

  // one converted result beat
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second_of_minute;
  } date_t;

  localparam int unsigned DateW = $bits(date_t);

endpackage

@@ src/epoch_to_calendar_date.sv @@
// top level of the epoch-to-calendar-date converter
// depends on e2c_pkg, e2c_front, e2c_fifo and e2c_back
//
// Usage:
//   Input queue: drive epoch_seconds_i and raise push; a beat is taken at a
//   clock edge where push is high and full is low. Up to MidDepth beats wait
//   between the front end and the conversion pipeline.
//   Result queue: while empty is low the oldest result is on year_o ..
//   second_of_minute_o; raise pop to take it. Results leave in input order.
//   Offset: utc_offset_we_i writes utc_offset_seconds_i (signed seconds)
//   at the clock edge; write it only while no beat is in flight.
//   Throughput: one beat per cycle while a result slot can be reserved,
//   set by the five-stage pipeline and a result queue of OutDepth entries
//   that is reserved ahead of each beat. When the receiver stops popping,
//   the pipeline stops taking beats once the result queue is reserved, the
//   input queue fills and full rises.
//   Reset (rst_ni low, asynchronous) empties both queues, drops beats in
//   flight and sets the offset to 28800 seconds.
module epoch_to_calendar_date #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        utc_offset_we_i,
  input  logic [e2c_pkg::OffsetW-1:0] utc_offset_seconds_i,
  input  logic                        push,
  output logic                        full,
  input  logic [e2c_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [11:0]                 year_o,
  output logic [3:0]                  month_o,
  output logic [4:0]                  day_o,
  output logic [4:0]                  hour_o,
  output logic [5:0]                  minute_o,
  output logic [5:0]                  second_of_minute_o
);

  import e2c_pkg::*;

  logic [EpochW-1:0] local_sec;
  logic [EpochW-1:0] mid_data;
  logic              mid_empty;
  logic              mid_pop;
  logic              out_push;
  logic              out_pop;
  date_t             out_wdata;
  logic [DateW-1:0]  out_rdata;
  date_t             res;

  // front end: offset and clamp
  e2c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .offset_we_i (utc_offset_we_i),
    .offset_i    (utc_offset_seconds_i),
    .epoch_i     (epoch_seconds_i),
    .local_o     (local_sec)
  );

  // queue between front and back
  e2c_fifo #(
    .Width (EpochW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (local_sec),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_data),
    .empty_o (mid_empty)
  );

  // conversion pipeline
  e2c_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_data),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata),
    .out_pop_i   (out_pop)
  );

  // result queue
  assign out_pop = pop && !empty;

  e2c_fifo #(
    .Width (DateW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign res                = date_t'(out_rdata);
  assign year_o             = res.year;
  assign month_o            = res.month;
  assign day_o              = res.day;
  assign hour_o             = res.hour;
  assign minute_o           = res.minute;
  assign second_of_minute_o = res.second_of_minute;

endmodule

@@ src/e2c_fifo.sv @@
// small register-based queue with registered storage, used between stages
// no package dependency; width and depth are parameters
module e2c_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/e2c_front.sv @@
// front end: holds the time-zone offset, adds it to the second count and clamps
// depends on e2c_pkg
module e2c_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            offset_we_i,
  input  logic [e2c_pkg::OffsetW-1:0]     offset_i,
  input  logic [e2c_pkg::EpochW-1:0]      epoch_i,
  output logic [e2c_pkg::EpochW-1:0]      local_o
);

  import e2c_pkg::*;

  logic signed [OffsetW-1:0] offset_q;
  logic signed [EpochW+1:0]  sum;

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (offset_we_i) begin
      offset_q <= $signed(offset_i);
    end
  end

  // add and clamp to the unsigned 32-bit range
  always_comb begin
    sum = $signed({2'b00, epoch_i}) + (EpochW + 2)'(offset_q);
    priority if (sum[EpochW+1]) begin
      local_o = '0;
    end else if (sum[EpochW]) begin
      local_o = '1;
    end else begin
      local_o = sum[EpochW-1:0];
    end
  end

endmodule

@@ src/e2c_back.sv @@
// back end: five-stage conversion pipeline from local seconds to calendar fields
// depends on e2c_pkg; reserves result queue space before taking a beat
module e2c_back #(
  parameter int unsigned OutDepth = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       mid_empty_i,
  input  logic [e2c_pkg::EpochW-1:0] mid_data_i,
  output logic                       mid_pop_o,
  output logic                       out_push_o,
  output e2c_pkg::date_t             out_data_o,
  input  logic                       out_pop_i
);

  import e2c_pkg::*;

  localparam int unsigned RsvW = $clog2(OutDepth + 1);

  // reciprocal constants: floor(x * R >> S) equals x / divisor over the used range
  localparam logic [25:0] DayRecip   = 26'd50903317;  // x / 675, x < 2^25
  localparam logic [16:0] CycleRecip = 17'd91868;     // x / 1461, x < 49711
  localparam logic [17:0] HourRecip  = 18'd149131;    // x / 3600, x < 86400
  localparam logic [12:0] MinRecip   = 13'd4370;      // x / 60, x < 3600

  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [31:0] local_s;
    logic [50:0] day_prod;
  } st1_t;

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
    logic [32:0] cyc_prod;
  } st2_t;

  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  doy;
    logic        leap;
    logic [16:0] sod;
    logic [34:0] hour_prod;
  } st3_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [11:0] rem_h;
  } st4_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [11:0] rem_h;
    logic [24:0] min_prod;
  } st5_t;

  st1_t s1_q, s1_d;
  st2_t s2_q, s2_d;
  st3_t s3_q, s3_d;
  st4_t s4_q, s4_d;
  st5_t s5_q, s5_d;
  logic [4:0]      vld_q;
  logic [RsvW-1:0] rsv_q, rsv_d;
  logic            issue;

  // credit check: a beat enters only if its result slot is already reserved
  assign issue     = !mid_empty_i && (rsv_q < RsvW'(OutDepth));
  assign mid_pop_o = issue;

  always_comb begin
    unique case ({issue, out_pop_i})
      2'b10:   rsv_d = rsv_q + 1'b1;
      2'b01:   rsv_d = rsv_q - 1'b1;
      default: rsv_d = rsv_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q <= '0;
      vld_q <= '0;
    end else begin
      rsv_q <= rsv_d;
      vld_q <= {vld_q[3:0], issue};
    end
  end

  // stage 1: days = local / 86400 via (local >> 7) / 675
  always_comb begin
    s1_d.local_s  = mid_data_i;
    s1_d.day_prod = 51'(mid_data_i[31:7]) * 51'(DayRecip);
  end

  // stage 2: second of day and four-year cycle product
  always_comb begin
    logic [15:0] days;
    days         = s1_q.day_prod[50:35];
    s2_d.days    = days;
    s2_d.sod     = 17'(s1_q.local_s - 32'(days) * 32'd86400);
    s2_d.cyc_prod = 33'(days) * 33'(CycleRecip);
  end

  // stage 3: year within the cycle, day of year, hour product
  always_comb begin
    logic [5:0]  cycles;
    logic [10:0] d;
    logic [1:0]  yoff;
    cycles = s2_q.cyc_prod[32:27];
    d      = 11'(s2_q.days - 16'(cycles) * 16'd1461);
    s3_d.leap = 1'b0;
    priority if (d < 11'd365) begin
      yoff     = 2'd0;
      s3_d.doy = 9'(d);
    end else if (d < 11'd730) begin
      yoff     = 2'd1;
      s3_d.doy = 9'(d - 11'd365);
    end else if (d < 11'd1096) begin
      yoff      = 2'd2;
      s3_d.doy  = 9'(d - 11'd730);
      s3_d.leap = 1'b1;
    end else begin
      yoff     = 2'd3;
      s3_d.doy = 9'(d - 11'd1096);
    end
    s3_d.year      = 12'd1970 + {4'd0, cycles, 2'b00} + {10'd0, yoff};
    s3_d.sod       = s2_q.sod;
    s3_d.hour_prod = 35'(s2_q.sod) * 35'(HourRecip);
  end

  // stage 4: month lookup over cumulative month starts, hour and remainder
  always_comb begin
    logic [8:0] st;
    logic [8:0] mst;
    logic [3:0] mon;
    logic [4:0] hour;
    mst = '0;
    mon = 4'd1;
    st  = '0;
    for (int m = 0; m < 12; m++) begin
      st = MonthStart[m] + ((s3_q.leap && m >= 2) ? 9'd1 : 9'd0);
      if (s3_q.doy >= st) begin
        mon = 4'(m + 1);
        mst = st;
      end
    end
    hour        = s3_q.hour_prod[33:29];
    s4_d.year   = s3_q.year;
    s4_d.month  = mon;
    s4_d.day    = 5'(s3_q.doy - mst + 9'd1);
    s4_d.hour   = hour;
    s4_d.rem_h  = 12'(s3_q.sod - 17'(hour) * 17'd3600);
  end

  // stage 5: minute product
  always_comb begin
    s5_d.year     = s4_q.year;
    s5_d.month    = s4_q.month;
    s5_d.day      = s4_q.day;
    s5_d.hour     = s4_q.hour;
    s5_d.rem_h    = s4_q.rem_h;
    s5_d.min_prod = 25'(s4_q.rem_h) * 25'(MinRecip);
  end

  // last step: minute and second, written into the result queue
  always_comb begin
    logic [5:0] minute;
    minute                      = s5_q.min_prod[23:18];
    out_data_o.year             = s5_q.year;
    out_data_o.month            = s5_q.month;
    out_data_o.day              = s5_q.day;
    out_data_o.hour             = s5_q.hour;
    out_data_o.minute           = minute;
    out_data_o.second_of_minute = 6'(s5_q.rem_h - 12'(minute) * 12'd60);
  end

  assign out_push_o = vld_q[4];

  // stage payload, no reset
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
    s5_q <= s5_d;
  end

endmodule

@@ src/e2c_checker.sv @@
// port-level checks for epoch_to_calendar_date, attached with a bind
// depends only on the top level's ports
module e2c_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_of_minute_o
);

  logic [15:0] pending_q;
  logic        in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // beats taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {15'd0, in_beat} - {15'd0, out_beat};
    end
  end

  // no result shows up without a beat taken before it
  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != 16'd0)
    else $error("result shown with no beat pending");

  // a waiting result holds while not popped
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(year_o) && $stable(month_o) && $stable(day_o)
      && $stable(hour_o) && $stable(minute_o) && $stable(second_of_minute_o))
    else $error("waiting result changed");

  // date fields stay in range
  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> year_o >= 12'd1970 && year_o <= 12'd2106 && month_o >= 4'd1
      && month_o <= 4'd12 && day_o >= 5'd1)
    else $error("date field out of range");

  // time fields stay in range
  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> hour_o < 5'd24 && minute_o < 6'd60 && second_of_minute_o < 6'd60)
    else $error("time field out of range");

endmodule

bind epoch_to_calendar_date e2c_checker u_e2c_checker (.*);

@@ bench/tb_epoch_to_calendar_date.sv @@
// self-checking bench for epoch_to_calendar_date: directed and random epoch beats
// with random bursts, result stalls and offset changes; depends on e2c_pkg and the rtl
module tb_epoch_to_calendar_date;
  timeunit 1ns;
  timeprecision 1ps;

  import e2c_pkg::*;

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned DaysPerQuad  = 1461;
  localparam int unsigned FirstYear    = 1970;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PrintCap     = 40;

  // one accepted epoch beat and the date it must turn into
  typedef struct {
    logic [EpochW-1:0] epoch;
    date_t             date;
  } conversion_t;

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                utc_offset_we_i      = 1'b0;
  logic [OffsetW-1:0]  utc_offset_seconds_i = '0;
  logic                push                 = 1'b0;
  logic                full;
  logic [EpochW-1:0]   epoch_seconds_i      = '0;
  logic                empty;
  logic                pop                  = 1'b0;
  logic [11:0]         year_o;
  logic [3:0]          month_o;
  logic [4:0]          day_o;
  logic [4:0]          hour_o;
  logic [5:0]          minute_o;
  logic [5:0]          second_of_minute_o;

  // offset the block holds, tracked on every register write
  logic signed [OffsetW-1:0] offset_model = OffsetReset;
  conversion_t               pending_dates_q[$];
  int unsigned               mismatch_count = 0;
  bit                        hold_off_req   = 1'b0;

  always #1 clk_i = ~clk_i;

  epoch_to_calendar_date dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .utc_offset_we_i     (utc_offset_we_i),
    .utc_offset_seconds_i(utc_offset_seconds_i),
    .push                (push),
    .full                (full),
    .epoch_seconds_i     (epoch_seconds_i),
    .empty               (empty),
    .pop                 (pop),
    .year_o              (year_o),
    .month_o             (month_o),
    .day_o               (day_o),
    .hour_o              (hour_o),
    .minute_o            (minute_o),
    .second_of_minute_o  (second_of_minute_o)
  );

  // month lengths under the four-year rule
  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    case (m)
      1:       return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // local calendar date for a utc second count and a signed offset
  function automatic date_t calendar_of(input logic [EpochW-1:0] utc,
                                        input logic signed [OffsetW-1:0] ofs);
    longint      sum;
    int unsigned secs, days, sod, d, yr, mon, mlen;
    bit          leap;
    date_t       r;
    sum = longint'(utc) + longint'(ofs);
    if (sum < 0) begin
      secs = 0;
    end else if (sum > longint'(32'hFFFF_FFFF)) begin
      secs = 32'hFFFF_FFFF;
    end else begin
      secs = 32'(sum);
    end
    days = secs / SecsPerDay;
    sod  = secs % SecsPerDay;
    yr   = FirstYear + 4 * (days / DaysPerQuad);
    d    = days % DaysPerQuad;
    leap = 1'b0;
    // third year of each four-year cycle is the leap year
    if (d >= 1096) begin
      yr += 3;
      d  -= 1096;
    end else if (d >= 730) begin
      yr  += 2;
      d   -= 730;
      leap = 1'b1;
    end else if (d >= 365) begin
      yr += 1;
      d  -= 365;
    end
    mon = 12;
    for (int m = 0; m < 12; m++) begin
      mlen = days_in_month(m, leap);
      if (d < mlen) begin
        mon = m + 1;
        break;
      end
      d -= mlen;
    end
    r.year             = 12'(yr);
    r.month            = 4'(mon);
    r.day              = 5'(d + 1);
    r.hour             = 5'(sod / 3600);
    r.minute           = 6'((sod / 60) % 60);
    r.second_of_minute = 6'(sod % 60);
    return r;
  endfunction

  // random epoch, weighted toward clamp zones and local day, month and year edges
  function automatic logic [EpochW-1:0] pick_epoch();
    longint      t;
    longint      day_n;
    longint      ofs;
    int unsigned yidx;
    int unsigned mcount;
    ofs = longint'(offset_model);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = longint'($urandom);
      4:          t = longint'($urandom_range(0, 200000));
      5:          t = longint'(32'hFFFF_FFFF) - longint'($urandom_range(0, 200000));
      6, 7: begin
        day_n = longint'($urandom_range(0, 49709));
        case ($urandom_range(0, 2))
          0:       t = day_n * SecsPerDay;
          1:       t = day_n * SecsPerDay + SecsPerDay - 1;
          default: t = day_n * SecsPerDay + longint'($urandom_range(0, SecsPerDay - 1));
        endcase
        t = t - ofs;
      end
      default: begin
        yidx  = $urandom_range(0, 136);
        day_n = longint'((yidx / 4) * DaysPerQuad);
        case (yidx % 4)
          1:       day_n += 365;
          2:       day_n += 730;
          3:       day_n += 1096;
          default: ;
        endcase
        mcount = $urandom_range(0, 11);
        for (int m = 0; m < 12; m++) begin
          if (m < mcount) begin
            day_n += longint'(days_in_month(m, (yidx % 4) == 2));
          end
        end
        t = day_n * SecsPerDay - ofs - longint'($urandom_range(0, 1));
      end
    endcase
    if (t < 0) begin
      t = 0;
    end else if (t > longint'(32'hFFFF_FFFF)) begin
      t = longint'(32'hFFFF_FFFF);
    end
    return 32'(t);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want,
                                 input logic [EpochW-1:0] epoch);
    if (mismatch_count < PrintCap) begin
      $display("[%0t] date check failed: %s got %0d want %0d (epoch %0d, offset %0d)",
               $realtime, what, got, want, epoch, offset_model);
    end
    mismatch_count++;
  endtask

  // offer one epoch beat and hold it until taken; push stays high afterwards
  task automatic send_epoch(input logic [EpochW-1:0] secs);
    conversion_t conv;
    push            <= 1'b1;
    epoch_seconds_i <= secs;
    conv.epoch = secs;
    conv.date  = calendar_of(secs, offset_model);
    do @(posedge clk_i); while (full);
    pending_dates_q.push_back(conv);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender pauses until every expected date has come back
  task automatic drain_dates();
    push <= 1'b0;
    while (pending_dates_q.size() != 0) @(posedge clk_i);
  endtask

  // offset register is written only with nothing in flight
  task automatic write_offset(input logic signed [OffsetW-1:0] value);
    drain_dates();
    utc_offset_we_i      <= 1'b1;
    utc_offset_seconds_i <= value;
    @(posedge clk_i);
    utc_offset_we_i <= 1'b0;
    offset_model = value;
  endtask

  // random bursts with random gaps, some bursts run back to back
  task automatic send_random_phase(input int unsigned count);
    int unsigned burst;
    while (count != 0) begin
      burst = $urandom_range(1, 16);
      if (burst > count) burst = count;
      repeat (burst) send_epoch(pick_epoch());
      count -= burst;
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // offset out of reset, including a clamp at the top
  task automatic test_reset_offset();
    send_epoch(32'd0);
    send_epoch(32'd1_000_000_000);
    send_epoch(32'hFFFF_FFFF);
    drain_dates();
  endtask

  // sums below zero and beyond 32 bits clamp
  task automatic test_clamping();
    write_offset(-17'sd43200);
    send_epoch(32'd0);
    send_epoch(32'd43199);
    send_epoch(32'd43200);
    send_epoch(32'd43201);
    write_offset(17'sd50400);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'hFFFF_FFFF - 32'd50400);
    send_epoch(32'hFFFF_FFFF - 32'd50401);
    drain_dates();
  endtask

  // full 17-bit range beyond the nominal offsets
  task automatic test_offset_extremes();
    write_offset(17'sh10000);
    send_epoch(32'd65535);
    send_epoch(32'd65536);
    write_offset(17'sh0FFFF);
    send_epoch(32'd0);
    send_epoch(32'hFFFF_0000);
    drain_dates();
  endtask

  // last day of plain and leap years, leap day, and the 2100 leap day
  task automatic test_calendar_edges();
    write_offset('0);
    send_epoch(32'd31_535_999);
    send_epoch(32'd31_536_000);
    send_epoch(32'd68_169_600);
    send_epoch(32'd94_694_399);
    send_epoch(32'd94_694_400);
    send_epoch(32'd4_102_444_799);
    send_epoch(32'd4_107_456_000);
    send_epoch(32'd4_107_542_400);
    send_epoch(32'd4_107_628_800);
    drain_dates();
  endtask

  // receiver holds off while beats keep coming, so full must rise
  task automatic test_full_backpressure();
    write_offset(17'sd3600);
    hold_off_req = 1'b1;
    repeat (48) send_epoch(pick_epoch());
    drain_dates();
  endtask

  // random beats under a series of offsets
  task automatic test_random_traffic();
    logic signed [OffsetW-1:0] offsets[7];
    offsets[0] = -17'sd43200;
    offsets[1] = 17'sd50400;
    offsets[2] = '0;
    offsets[3] = OffsetW'($signed($urandom_range(0, 93600)) - 43200);
    offsets[4] = OffsetW'($urandom);
    offsets[5] = OffsetReset;
    offsets[6] = OffsetW'($urandom);
    foreach (offsets[i]) begin
      write_offset(offsets[i]);
      send_random_phase(170);
    end
    drain_dates();
  endtask

  // result side: check each popped beat, stall on a changing pattern
  initial begin : date_sink
    conversion_t want;
    date_t       got;
    int unsigned stall_left;
    int unsigned mode_left;
    int unsigned mode;
    logic [15:0] pop_mask;
    stall_left = 0;
    mode_left  = 0;
    mode       = 0;
    pop_mask   = '1;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = {year_o, month_o, day_o, hour_o, minute_o, second_of_minute_o};
        if (pending_dates_q.size() == 0) begin
          report_mismatch("unexpected date beat, year", got.year, 0, '0);
        end else begin
          want = pending_dates_q.pop_front();
          if (got.year != want.date.year)
            report_mismatch("year", got.year, want.date.year, want.epoch);
          if (got.month != want.date.month)
            report_mismatch("month", got.month, want.date.month, want.epoch);
          if (got.day != want.date.day)
            report_mismatch("day", got.day, want.date.day, want.epoch);
          if (got.hour != want.date.hour)
            report_mismatch("hour", got.hour, want.date.hour, want.epoch);
          if (got.minute != want.date.minute)
            report_mismatch("minute", got.minute, want.date.minute, want.epoch);
          if (got.second_of_minute != want.date.second_of_minute)
            report_mismatch("second", got.second_of_minute, want.date.second_of_minute,
                            want.epoch);
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
        pop_mask  = 16'($urandom);
      end
      mode_left--;
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LongHold;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: begin
            pop <= pop_mask[0];
            pop_mask = {pop_mask[0], pop_mask[15:1]};
          end
        endcase
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_offset();
    test_clamping();
    test_offset_extremes();
    test_calendar_edges();
    test_full_backpressure();
    test_random_traffic();
    drain_dates();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
